// ----- design/hvd_pkg.sv -----
package hvd_pkg;

   localparam int LANES = 4;
   localparam int SQRT_LANES = 2;
   localparam int ROOT_BITS = 31;
   localparam int RADIUS_W = 22;
   localparam int DIST_W = 24;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 22'd880657;
   localparam logic REG_EARTH_RADIUS = 1'b0;

   // reciprocal of 45 scaled by 2^36, floor
   localparam logic [30:0] RECIP_45 = 31'd1527099483;
   localparam int RECIP_SHIFT = 36;
   localparam logic [6:0] DIVISOR = 7'd45;
   localparam logic [6:0] DIVISOR_HALF = 7'd22;

   localparam logic signed [33:0] CORDIC_K = 34'sd652032875;
   localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;
   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [63:0] ROUND_Q30 = 64'h2000_0000;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_type;

   function automatic logic [31:0] atan_at(input logic [4:0] idx);
      logic [31:0] res;
      case (idx)
         5'd0: res = 32'h20000000;
         5'd1: res = 32'h12E4051E;
         5'd2: res = 32'h09FB385B;
         5'd3: res = 32'h051111D4;
         5'd4: res = 32'h028B0D43;
         5'd5: res = 32'h0145D7E1;
         5'd6: res = 32'h00A2F61E;
         5'd7: res = 32'h00517C55;
         5'd8: res = 32'h0028BE53;
         5'd9: res = 32'h00145F2F;
         5'd10: res = 32'h000A2F98;
         5'd11: res = 32'h000517CC;
         5'd12: res = 32'h00028BE6;
         5'd13: res = 32'h000145F3;
         5'd14: res = 32'h0000A2FA;
         5'd15: res = 32'h0000517D;
         5'd16: res = 32'h000028BE;
         5'd17: res = 32'h0000145F;
         5'd18: res = 32'h00000A30;
         5'd19: res = 32'h00000518;
         5'd20: res = 32'h0000028C;
         5'd21: res = 32'h00000146;
         5'd22: res = 32'h000000A3;
         5'd23: res = 32'h00000051;
         5'd24: res = 32'h00000029;
         5'd25: res = 32'h00000014;
         5'd26: res = 32'h0000000A;
         5'd27: res = 32'h00000005;
         5'd28: res = 32'h00000003;
         5'd29: res = 32'h00000001;
         5'd30: res = 32'h00000001;
         default: res = 32'h00000000;
      endcase
      return res;
   endfunction

endpackage

// ----- design/hvd_angle.sv -----
module hvd_angle #(
   parameter int COORD_FRAC_BITS = 20
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic vld_i,
   input  logic signed [27:0] lat_a_i,
   input  logic signed [28:0] lon_a_i,
   input  logic signed [27:0] lat_b_i,
   input  logic signed [28:0] lon_b_i,
   output logic vld_o,
   output logic [31:0] ang_o [hvd_pkg::LANES]
);

   localparam int SH_FULL = 32 - COORD_FRAC_BITS;
   localparam int V2W = SH_FULL + 3;
   localparam int Q0W = 24;
   localparam int Q1W = V2W - 5;

   logic [4:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], vld_i};
      end
   end

   assign vld_o = vld_ff[4];

   for (genvar l = 0; l < hvd_pkg::LANES; l++) begin : g_lane
      localparam int SHL = (l < 2) ? SH_FULL : SH_FULL - 1;
      localparam int KSH = SHL - 3;

      logic signed [29:0] val_c;
      logic [28:0] mag1_in, mag1_ff, mag2_ff;
      logic neg1_ff, neg2_ff, neg3_ff, neg4_ff;
      logic [Q0W-1:0] q0p_in, q0p_ff, q0_in, q0_ff, q0b_ff;
      logic [6:0] r7_c, r2_c;
      logic ge_c;
      logic [5:0] r6_c;
      logic [V2W-1:0] v2_in, v2_ff, v2b_ff;
      logic [Q1W-1:0] q1p_in, q1p_ff, q1_c;
      logic [31:0] m_c, ang_in, ang_ff;

      if (l == 0) begin : g_src
         assign val_c = 30'(lat_a_i);
      end else if (l == 1) begin : g_src
         assign val_c = 30'(lat_b_i);
      end else if (l == 2) begin : g_src
         assign val_c = 30'(lat_b_i) - 30'(lat_a_i);
      end else begin : g_src
         assign val_c = 30'(lon_b_i) - 30'(lon_a_i);
      end

      assign mag1_in = (val_c < 0) ? 29'(-val_c) : 29'(val_c);
      assign q0p_in = Q0W'((60'(mag1_ff) * 60'(hvd_pkg::RECIP_45)) >> hvd_pkg::RECIP_SHIFT);

      assign r7_c = 7'(mag2_ff - 29'(q0p_ff) * 29'(hvd_pkg::DIVISOR));
      assign ge_c = (r7_c >= hvd_pkg::DIVISOR);
      assign q0_in = q0p_ff + Q0W'(ge_c);
      assign r6_c = ge_c ? 6'(r7_c - hvd_pkg::DIVISOR) : 6'(r7_c);
      assign v2_in = (V2W'(r6_c) << KSH) + V2W'(hvd_pkg::DIVISOR_HALF);

      assign q1p_in = Q1W'((64'(v2_ff) * 64'(hvd_pkg::RECIP_45)) >> hvd_pkg::RECIP_SHIFT);

      assign r2_c = 7'(v2b_ff - V2W'(q1p_ff) * V2W'(hvd_pkg::DIVISOR));
      assign q1_c = q1p_ff + Q1W'(r2_c >= hvd_pkg::DIVISOR);
      assign m_c = 32'(64'(q0b_ff) << KSH) + 32'(q1_c);
      assign ang_in = neg4_ff ? (32'd0 - m_c) : m_c;

      always_ff @(posedge clock) begin
         if (en) begin
            mag1_ff <= mag1_in;
            neg1_ff <= (val_c < 0);
            q0p_ff <= q0p_in;
            mag2_ff <= mag1_ff;
            neg2_ff <= neg1_ff;
            q0_ff <= q0_in;
            v2_ff <= v2_in;
            neg3_ff <= neg2_ff;
            q1p_ff <= q1p_in;
            q0b_ff <= q0_ff;
            v2b_ff <= v2_ff;
            neg4_ff <= neg3_ff;
            ang_ff <= ang_in;
         end
      end

      assign ang_o[l] = ang_ff;
   end

endmodule

// ----- design/hvd_rot.sv -----
module hvd_rot #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic vld_i,
   input  logic [31:0] ang_i [hvd_pkg::LANES],
   output logic vld_o,
   output logic signed [31:0] val_o [hvd_pkg::LANES]
);

   localparam int N = CORDIC_STAGES;
   localparam int XW = 34;

   logic [N+1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N:0], vld_i};
      end
   end

   assign vld_o = vld_ff[N+1];

   for (genvar l = 0; l < hvd_pkg::LANES; l++) begin : g_lane
      logic signed [XW-1:0] x_ff [N+1];
      logic signed [XW-1:0] x_in [N+1];
      logic signed [XW-1:0] y_ff [N+1];
      logic signed [XW-1:0] y_in [N+1];
      logic signed [31:0] z_ff [N+1];
      logic signed [31:0] z_in [N+1];
      hvd_pkg::quad_type quad_ff [N+1];
      hvd_pkg::quad_type quad_in [N+1];
      logic [31:0] t_c;
      logic signed [31:0] z0_c;
      logic signed [XW-1:0] cs_c, sn_c;
      logic signed [31:0] val_in, val_ff;

      assign t_c = ang_i[l] + hvd_pkg::EIGHTH_TURN;
      assign z0_c = $signed({2'b00, t_c[29:0]}) - $signed(hvd_pkg::EIGHTH_TURN);

      always_comb begin
         x_in[0] = hvd_pkg::CORDIC_K;
         y_in[0] = '0;
         z_in[0] = z0_c;
         quad_in[0] = hvd_pkg::quad_type'(t_c[31:30]);
         for (int i = 0; i < N; i++) begin
            if (z_ff[i] >= 0) begin
               x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
               y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
               z_in[i+1] = z_ff[i] - $signed(hvd_pkg::atan_at(5'(i)));
            end else begin
               x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
               y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
               z_in[i+1] = z_ff[i] + $signed(hvd_pkg::atan_at(5'(i)));
            end
            quad_in[i+1] = quad_ff[i];
         end
      end

      always_comb begin
         case (quad_ff[N])
            hvd_pkg::QUAD_I: begin
               cs_c = x_ff[N];
               sn_c = y_ff[N];
            end
            hvd_pkg::QUAD_II: begin
               cs_c = -y_ff[N];
               sn_c = x_ff[N];
            end
            hvd_pkg::QUAD_III: begin
               cs_c = -x_ff[N];
               sn_c = -y_ff[N];
            end
            default: begin
               cs_c = y_ff[N];
               sn_c = -x_ff[N];
            end
         endcase
      end

      // latitudes need the cosine, half differences the sine
      assign val_in = (l < 2) ? 32'(cs_c) : 32'(sn_c);

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= z_in;
            quad_ff <= quad_in;
            val_ff <= val_in;
         end
      end

      assign val_o[l] = val_ff;
   end

endmodule

// ----- design/hvd_isqrt.sv -----
module hvd_isqrt (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic vld_i,
   input  logic [30:0] u_i [hvd_pkg::SQRT_LANES],
   output logic vld_o,
   output logic [30:0] root_o [hvd_pkg::SQRT_LANES]
);

   localparam int NB = hvd_pkg::ROOT_BITS;

   logic [NB:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NB-1:0], vld_i};
      end
   end

   assign vld_o = vld_ff[NB];

   for (genvar l = 0; l < hvd_pkg::SQRT_LANES; l++) begin : g_lane
      logic [61:0] rad_ff [NB+1];
      logic [61:0] rad_in [NB+1];
      logic [34:0] rem_ff [NB+1];
      logic [34:0] rem_in [NB+1];
      logic [30:0] root_ff [NB+1];
      logic [30:0] root_in [NB+1];
      logic [34:0] pull_c [NB];
      logic [34:0] trial_c [NB];

      always_comb begin
         rad_in[0] = 62'(u_i[l]) << 30;
         rem_in[0] = '0;
         root_in[0] = '0;
         for (int k = 0; k < NB; k++) begin
            pull_c[k] = {rem_ff[k][32:0], rad_ff[k][61:60]};
            trial_c[k] = {2'b00, root_ff[k], 2'b01};
            rad_in[k+1] = rad_ff[k] << 2;
            if (pull_c[k] >= trial_c[k]) begin
               rem_in[k+1] = pull_c[k] - trial_c[k];
               root_in[k+1] = {root_ff[k][29:0], 1'b1};
            end else begin
               rem_in[k+1] = pull_c[k];
               root_in[k+1] = {root_ff[k][29:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff <= rad_in;
            rem_ff <= rem_in;
            root_ff <= root_in;
         end
      end

      assign root_o[l] = root_ff[NB];
   end

endmodule

// ----- design/hvd_vec.sv -----
module hvd_vec #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic vld_i,
   input  logic [30:0] x_i,
   input  logic [30:0] y_i,
   output logic vld_o,
   output logic [30:0] z_o
);

   localparam int N = CORDIC_STAGES;
   localparam int XW = 34;

   logic [N+1:0] vld_ff;
   logic signed [XW-1:0] x_ff [N+1];
   logic signed [XW-1:0] x_in [N+1];
   logic signed [XW-1:0] y_ff [N+1];
   logic signed [XW-1:0] y_in [N+1];
   logic signed [32:0] z_ff [N+1];
   logic signed [32:0] z_in [N+1];
   logic [30:0] zo_in, zo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N:0], vld_i};
      end
   end

   always_comb begin
      x_in[0] = $signed(34'(x_i));
      y_in[0] = $signed(34'(y_i));
      z_in[0] = '0;
      for (int i = 0; i < N; i++) begin
         if (y_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + $signed(33'(hvd_pkg::atan_at(5'(i))));
         end else begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - $signed(33'(hvd_pkg::atan_at(5'(i))));
         end
      end
   end

   assign zo_in = z_ff[N][32] ? '0 : 31'(z_ff[N]);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         zo_ff <= zo_in;
      end
   end

   assign vld_o = vld_ff[N+1];
   assign z_o = zo_ff;

endmodule

// ----- design/haversine_distance.sv -----
// throughput: one beat per cycle; every stage is registered and the whole pipe
// advances together, held only while a finished rsp beat waits for rsp_ready
// the 31-step root stages and the two cordic chains set the depth
// reset clears all valid bits and loads the earth radius with 3440.065 nm
module haversine_distance #(
   parameter int COORD_FRAC_BITS = 20,
   parameter int CORDIC_STAGES = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [27:0] req_lat_a,
   input  logic signed [28:0] req_lon_a,
   input  logic signed [27:0] req_lat_b,
   input  logic signed [28:0] req_lon_b,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [23:0] rsp_distance_q8,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [2:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   logic en;
   logic csr_wr;
   logic [hvd_pkg::RADIUS_W-1:0] radius_ff;

   logic ang_vld;
   logic [31:0] ang [hvd_pkg::LANES];
   logic rot_vld;
   logic signed [31:0] rot_val [hvd_pkg::LANES];

   logic signed [63:0] p_prod_c;
   logic [31:0] sd_mag_c, so_mag_c;
   logic signed [31:0] p_in, p_ff;
   logic [32:0] sqd_in, sqd_ff, sqo_in, sqo_ff, sqd2_ff;
   logic m1_vld_ff, m2_vld_ff, m3_vld_ff;

   logic signed [65:0] t_prod_c;
   logic signed [35:0] t_in, t_ff;
   logic signed [36:0] a_sum_c;
   logic [30:0] a_in, a_ff, b_in, b_ff;

   logic sq_vld;
   logic [30:0] sq_u [hvd_pkg::SQRT_LANES];
   logic [30:0] sq_root [hvd_pkg::SQRT_LANES];

   logic vec_vld;
   logic [30:0] vec_z;

   logic [32:0] cq_in, cq_ff;
   logic cq_vld_ff;
   logic [63:0] dist_full_c;
   logic [23:0] dist_in, dist_ff;
   logic rsp_valid_ff;

   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // csr
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == hvd_pkg::REG_EARTH_RADIUS) ? 32'(radius_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= hvd_pkg::RADIUS_RESET;
      end else if (csr_wr && csr_paddr[2] == hvd_pkg::REG_EARTH_RADIUS) begin
         radius_ff <= csr_pwdata[hvd_pkg::RADIUS_W-1:0];
      end
   end

   hvd_angle #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_angle (
      .clock(clock),
      .reset(reset),
      .en(en),
      .vld_i(req_valid),
      .lat_a_i(req_lat_a),
      .lon_a_i(req_lon_a),
      .lat_b_i(req_lat_b),
      .lon_b_i(req_lon_b),
      .vld_o(ang_vld),
      .ang_o(ang)
   );

   hvd_rot #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) u_rot (
      .clock(clock),
      .reset(reset),
      .en(en),
      .vld_i(ang_vld),
      .ang_i(ang),
      .vld_o(rot_vld),
      .val_o(rot_val)
   );

   // products and squares
   assign p_prod_c = 64'(rot_val[0]) * 64'(rot_val[1]);
   assign sd_mag_c = rot_val[2][31] ? 32'(-rot_val[2]) : 32'(rot_val[2]);
   assign so_mag_c = rot_val[3][31] ? 32'(-rot_val[3]) : 32'(rot_val[3]);
   assign p_in = 32'(p_prod_c >>> 30);
   assign sqd_in = 33'((64'(sd_mag_c) * 64'(sd_mag_c)) >> 30);
   assign sqo_in = 33'((64'(so_mag_c) * 64'(so_mag_c)) >> 30);

   assign t_prod_c = 66'(p_ff) * 66'($signed({1'b0, sqo_ff}));
   assign t_in = 36'(t_prod_c >>> 30);

   // a clamped to 0..1
   assign a_sum_c = 37'(t_ff) + 37'($signed({1'b0, sqd2_ff}));

   always_comb begin
      if (a_sum_c < 0) begin
         a_in = '0;
      end else if (a_sum_c > $signed(37'(hvd_pkg::ONE_Q30))) begin
         a_in = hvd_pkg::ONE_Q30;
      end else begin
         a_in = 31'(a_sum_c);
      end
   end

   assign b_in = hvd_pkg::ONE_Q30 - a_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         m3_vld_ff <= 1'b0;
      end else if (en) begin
         m1_vld_ff <= rot_vld;
         m2_vld_ff <= m1_vld_ff;
         m3_vld_ff <= m2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
         sqd_ff <= sqd_in;
         sqo_ff <= sqo_in;
         t_ff <= t_in;
         sqd2_ff <= sqd_ff;
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign sq_u[0] = a_ff;
   assign sq_u[1] = b_ff;

   hvd_isqrt u_isqrt (
      .clock(clock),
      .reset(reset),
      .en(en),
      .vld_i(m3_vld_ff),
      .u_i(sq_u),
      .vld_o(sq_vld),
      .root_o(sq_root)
   );

   hvd_vec #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) u_vec (
      .clock(clock),
      .reset(reset),
      .en(en),
      .vld_i(sq_vld),
      .x_i(sq_root[1]),
      .y_i(sq_root[0]),
      .vld_o(vec_vld),
      .z_o(vec_z)
   );

   // central angle, then distance
   assign cq_in = 33'((64'(vec_z) * 64'(hvd_pkg::PI_Q30) + hvd_pkg::ROUND_Q30) >> 30);
   assign dist_full_c = (64'(radius_ff) * 64'(cq_ff) + hvd_pkg::ROUND_Q30) >> 30;
   assign dist_in = (dist_full_c > 64'(hvd_pkg::DIST_MAX)) ? hvd_pkg::DIST_MAX
                                                          : 24'(dist_full_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         cq_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         cq_vld_ff <= vec_vld;
         rsp_valid_ff <= cq_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cq_ff <= cq_in;
         dist_ff <= dist_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_distance_q8 = dist_ff;

   a_radius_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr && csr_paddr[2] == hvd_pkg::REG_EARTH_RADIUS
      |=> radius_ff == $past(csr_pwdata[hvd_pkg::RADIUS_W-1:0]))
      else $error("radius register did not take the written value");

   a_clamp_range: assert property (@(posedge clock) disable iff (reset)
      m3_vld_ff |-> a_ff <= hvd_pkg::ONE_Q30)
      else $error("haversine term above one");

   a_clamp_sum: assert property (@(posedge clock) disable iff (reset)
      m3_vld_ff |-> 32'(a_ff) + 32'(b_ff) == 32'(hvd_pkg::ONE_Q30))
      else $error("root operands do not sum to one");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("rsp beat valid right after reset");

endmodule

// ----- verif/tb_haversine_distance.sv -----
`timescale 1ns / 100ps

module tb_haversine_distance;

   typedef struct packed {
      logic signed [27:0] lat_a;
      logic signed [28:0] lon_a;
      logic signed [27:0] lat_b;
      logic signed [28:0] lon_b;
   } position_pair_type;

   localparam int STAGES = 24;
   localparam int FRAC = 20;
   localparam int LATENCY = 2 * STAGES + 46;
   localparam int LAT_MAX = 94371840;
   localparam int LON_MAX = 188743680;
   localparam int RANDOM_PAIRS = 1700;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [27:0] req_lat_a = '0;
   logic signed [28:0] req_lon_a = '0;
   logic signed [27:0] req_lat_b = '0;
   logic signed [28:0] req_lon_b = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [23:0] rsp_distance_q8;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   haversine_distance u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   position_pair_type pending_pairs[$];
   logic [23:0] expected_distances[$];
   logic [21:0] radius_model = hvd_pkg::RADIUS_RESET;
   int mismatch_count = 0;
   int distances_checked = 0;
   bit calm_phase = 1'b0;
   bit sender_hold = 1'b0;
   int long_stall = 0;

   task automatic report_mismatch(input string what, input logic [23:0] got,
                                  input logic [23:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   function automatic logic signed [63:0] floor_shift(input logic signed [63:0] v,
                                                      input int n);
      return v >>> n;
   endfunction

   function automatic logic [31:0] coord_to_turn(input logic signed [63:0] d,
                                                 input int sh);
      logic [63:0] mag;
      logic [63:0] q;
      mag = d < 0 ? 64'(-d) : 64'(d);
      q = ((mag << sh) + 64'd180) / 64'd360;
      return d < 0 ? 32'(-q) : 32'(q);
   endfunction

   task automatic rotate_unit(input logic [31:0] ang, output logic signed [63:0] cs,
                              output logic signed [63:0] sn);
      logic [31:0] t;
      hvd_pkg::quad_type quad;
      logic signed [63:0] x, y, z, xs, ys;
      t = ang + hvd_pkg::EIGHTH_TURN;
      quad = hvd_pkg::quad_type'(t[31:30]);
      z = $signed({34'd0, t[29:0]}) - 64'sh2000_0000;
      x = hvd_pkg::CORDIC_K;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (z >= 0) begin
            x -= ys; y += xs; z -= $signed({32'd0, hvd_pkg::atan_at(5'(i))});
         end else begin
            x += ys; y -= xs; z += $signed({32'd0, hvd_pkg::atan_at(5'(i))});
         end
      end
      case (quad)
         hvd_pkg::QUAD_I: begin cs = x; sn = y; end
         hvd_pkg::QUAD_II: begin cs = -y; sn = x; end
         hvd_pkg::QUAD_III: begin cs = -x; sn = -y; end
         default: begin cs = y; sn = -x; end
      endcase
   endtask

   function automatic logic signed [63:0] square_frac(input logic signed [63:0] v);
      logic [63:0] m;
      m = v < 0 ? 64'(-v) : 64'(v);
      return $signed((m * m) >> 30);
   endfunction

   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   task automatic great_circle_q8(input position_pair_type pp,
                                  output logic [23:0] dist_out);
      logic signed [63:0] c1, s1, c2, s2, cd, sd, co, so, p, a, x, y, z, xs, ys;
      logic signed [63:0] la, oa, lb, ob;
      logic [63:0] cq, d;
      la = pp.lat_a; oa = pp.lon_a; lb = pp.lat_b; ob = pp.lon_b;
      rotate_unit(coord_to_turn(la, 32 - FRAC), c1, s1);
      rotate_unit(coord_to_turn(lb, 32 - FRAC), c2, s2);
      rotate_unit(coord_to_turn(lb - la, 31 - FRAC), cd, sd);
      rotate_unit(coord_to_turn(ob - oa, 31 - FRAC), co, so);
      p = floor_shift(c1 * c2, 30);
      a = square_frac(sd) + floor_shift(p * square_frac(so), 30);
      if (a < 0) a = 0;
      if (a > 64'sd1073741824) a = 64'sd1073741824;
      y = $signed(floor_root(64'(a) << 30));
      x = $signed(floor_root(64'(64'sd1073741824 - a) << 30));
      z = 0;
      for (int i = 0; i < STAGES; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; z += $signed({32'd0, hvd_pkg::atan_at(5'(i))});
         end else begin
            x -= ys; y += xs; z -= $signed({32'd0, hvd_pkg::atan_at(5'(i))});
         end
      end
      if (z < 0) z = 0;
      cq = (64'(z) * 64'(hvd_pkg::PI_Q30) + hvd_pkg::ROUND_Q30) >> 30;
      d = (64'(radius_model) * cq + hvd_pkg::ROUND_Q30) >> 30;
      dist_out = d > 64'(hvd_pkg::DIST_MAX) ? hvd_pkg::DIST_MAX : d[23:0];
   endtask

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      position_pair_type nxt;
      logic [23:0] want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            great_circle_q8({req_lat_a, req_lon_a, req_lat_b, req_lon_b}, want);
            expected_distances.push_back(want);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_pairs.size() > 0 && !sender_hold) begin
               nxt = pending_pairs.pop_front();
               req_valid <= 1'b1;
               req_lat_a <= nxt.lat_a;
               req_lon_a <= nxt.lon_a;
               req_lat_b <= nxt.lat_b;
               req_lon_b <= nxt.lon_b;
               if (!calm_phase && $urandom_range(0, 9) == 0)
                  send_gap <= $urandom_range(1, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int recv_gap = 0;
   always @(posedge clock) begin
      logic [23:0] want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_distances.size() == 0) begin
               report_mismatch("unexpected beat", rsp_distance_q8, 24'd0);
            end else begin
               want = expected_distances.pop_front();
               if (rsp_distance_q8 !== want)
                  report_mismatch("distance_q8", rsp_distance_q8, want);
               distances_checked++;
            end
         end
         if (long_stall > 0) begin
            long_stall <= long_stall - 1;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm_phase && $urandom_range(0, 9) == 0)
               recv_gap <= $urandom_range(1, 10);
         end
      end
   end

   function automatic int rand_coord(input int lim);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return int'($urandom);
      if (r == 1) return ($urandom_range(0, 1) ? 1 : -1) * lim;
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   task automatic queue_pair(input int la, input int oa, input int lb, input int ob);
      position_pair_type pp;
      pp.lat_a = 28'(la); pp.lon_a = 29'(oa); pp.lat_b = 28'(lb); pp.lon_b = 29'(ob);
      pending_pairs.push_back(pp);
   endtask

   task automatic drain_all();
      while (pending_pairs.size() > 0 || req_valid || expected_distances.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic csr_write(input logic [21:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * hvd_pkg::REG_EARTH_RADIUS);
      csr_pwdata <= 32'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      radius_model = val;
   endtask

   task automatic queue_random(input int n);
      for (int i = 0; i < n; i++)
         queue_pair(rand_coord(LAT_MAX), rand_coord(LON_MAX),
                    rand_coord(LAT_MAX), rand_coord(LON_MAX));
   endtask

   initial begin
      logic [21:0] radii[5] = '{22'd1, 22'd4194303, 22'd0, 22'd880657, 22'd1234567};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // directed
      queue_pair(0, 0, 0, 0);
      queue_pair(LAT_MAX, 0, -LAT_MAX, 0);
      queue_pair(0, LON_MAX, 0, -LON_MAX);
      queue_pair(0, 0, 0, LON_MAX);
      queue_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
      queue_pair(LAT_MAX, 0, LAT_MAX, LON_MAX);
      queue_pair(28'h7FF_FFFF, 29'h0FFF_FFFF, 28'h800_0000, 29'h1000_0000);
      queue_pair(28'h800_0000, 29'h1000_0000, 28'h7FF_FFFF, 29'h0FFF_FFFF);
      queue_pair(-1, -1, 1, 1);
      queue_pair(52428800, 10485760, 52428801, 10485760);
      queue_pair(0, 0, 0, 188743679);
      queue_pair(LAT_MAX - 1, 5, -LAT_MAX + 1, -5);
      drain_all();
      // long receiver stall while the sender keeps going
      long_stall = 300;
      queue_random(200);
      drain_all();
      foreach (radii[k]) begin
         csr_write(radii[k]);
         queue_random(k == 4 ? 500 : 200);
         while (pending_pairs.size() > 150)
            @(posedge clock);
         // sender pause until everything is back
         sender_hold = 1'b1;
         while (expected_distances.size() > 0 || req_valid)
            @(posedge clock);
         sender_hold = 1'b0;
         drain_all();
      end
      calm_phase = 1'b1;
      queue_random(200);
      drain_all();
      $display("covered %0d distances over %0d radius settings incl. zero and max radius",
               distances_checked, 6);
      $display("directed poles, antimeridian, full-scale and wrap coordinates included");
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- files.f -----
design/hvd_pkg.sv
design/hvd_angle.sv
design/hvd_rot.sv
design/hvd_isqrt.sv
design/hvd_vec.sv
design/haversine_distance.sv
verif/tb_haversine_distance.sv
